FILE: hdl/tss_pkg.sv
// Shared types and constants of the thread sync scheduler.
package tss_pkg;

	localparam int THREAD_SLOTS_DEF = 16;
	localparam int MUTEX_COUNT_DEF = 8;
	localparam int COND_COUNT_DEF = 8;
	localparam int QUEUE_COUNT_DEF = 1 + MUTEX_COUNT_DEF + COND_COUNT_DEF;

	localparam int TYPE_W = 3;
	localparam int THREAD_W = 4;
	localparam int MUTEX_W = 3;
	localparam int COND_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [TYPE_W-1:0] {
		REQ_CREATE,
		REQ_YIELD,
		REQ_EXIT,
		REQ_JOIN,
		REQ_LOCK,
		REQ_UNLOCK,
		REQ_WAIT,
		REQ_SIGNAL
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_EMPTY,
		ST_INVALID
	} status_t;

	typedef struct packed {
		logic [TYPE_W-1:0]   req_type;
		logic [THREAD_W-1:0] target_thread;
		logic [MUTEX_W-1:0]  mutex_sel;
		logic [COND_W-1:0]   cond_sel;
		logic                with_mutex;
	} req_t;

	typedef struct packed {
		logic [THREAD_W-1:0] running_now;
		logic                running_ok;
		logic                switched;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic {
		QOP_PUSH,
		QOP_POP
	} qe_op_t;

	typedef struct packed {
		logic   start;
		qe_op_t op;
	} qe_ctl_t;

endpackage

FILE: hdl/thread_sync_scheduler_unit.sv
// Thread sync scheduler top level: request decode, thread table and queue op sequencer.
// Queue ops on the head/tail and link memories run one at a time: a push passes the
// head/tail state, and a pop passes it and then the link state when the queue held
// more than one entry. A new item is taken once the previous result is in the output
// register. Reset empties all queues, frees all mutexes and leaves thread 0 running as
// the only live thread; no clearing pass.
module thread_sync_scheduler_unit #(
	parameter int THREAD_SLOTS = tss_pkg::THREAD_SLOTS_DEF,
	parameter int MUTEX_COUNT = tss_pkg::MUTEX_COUNT_DEF,
	parameter int COND_COUNT = tss_pkg::COND_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tss_pkg::rsp_t rsp
);

	localparam int QUEUE_COUNT = 1 + MUTEX_COUNT + COND_COUNT;
	localparam int TW = $clog2(THREAD_SLOTS);
	localparam int QW = $clog2(QUEUE_COUNT);
	localparam int MW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
	localparam int CW = (COND_COUNT > 1) ? $clog2(COND_COUNT) : 1;
	localparam int RUN_W = tss_pkg::THREAD_W;

	typedef enum logic [2:0] {
		C_IDLE,
		C_DECODE,
		C_LAUNCH,
		C_PUSH_W,
		C_MOVE_POP_W,
		C_MOVE_PUSH_W,
		C_DISP_W,
		C_RESULT
	} ctl_state_t;

	ctl_state_t st_q;
	ctl_state_t st_nxt;
	tss_pkg::req_t req_q;
	logic [TW-1:0] cur_q;
	logic cv_q;
	logic [THREAD_SLOTS-1:0] live_q;
	logic [THREAD_SLOTS-1:0] fin_q;
	logic [THREAD_SLOTS-1:0] jv_q;
	logic [TW-1:0] jthr_q [THREAD_SLOTS];
	logic [MUTEX_COUNT-1:0] lock_q;
	tss_pkg::status_t status_q;
	logic was_cv_q;
	logic [TW-1:0] was_cur_q;
	logic rsp_valid_q;
	tss_pkg::rsp_t rsp_q;

	logic push_en_q;
	logic [QW-1:0] push_q_q;
	logic [TW-1:0] push_t_q;
	logic move_en_q;
	logic [QW-1:0] move_src_q;
	logic move_rel_q;
	logic [MW-1:0] move_m_q;
	logic disp_en_q;

	tss_pkg::req_kind_t kind;
	logic tgt_ok;
	logic m_ok;
	logic c_ok;
	logic [TW-1:0] tidx;
	logic [MW-1:0] midx;
	logic [CW-1:0] cidx;
	logic [QW-1:0] mq;
	logic [QW-1:0] cq;
	logic bad;
	logic p_push;
	logic [QW-1:0] p_pq;
	logic [TW-1:0] p_pt;
	logic p_move;
	logic [QW-1:0] p_src;
	logic p_rel;
	logic p_disp;
	logic do_create;
	logic do_exit;
	logic do_join;
	logic do_lock;

	tss_pkg::qe_ctl_t eng_ctl;
	logic [QW-1:0] eng_queue;
	logic [TW-1:0] eng_thread;
	logic eng_done;
	logic [TW-1:0] eng_pop;
	logic [QUEUE_COUNT-1:0] eng_empty;
	logic try_push;
	logic try_move;
	logic try_disp;
	logic clr_lock;
	logic disp_none;
	logic rsp_load;
	logic sw;

	tss_queue_engine #(
		.THREAD_SLOTS(THREAD_SLOTS),
		.QUEUE_COUNT(QUEUE_COUNT)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(eng_ctl),
		.queue(eng_queue),
		.thread(eng_thread),
		.done(eng_done),
		.pop_thread(eng_pop),
		.empty(eng_empty)
	);

	always_comb begin
		kind = tss_pkg::req_kind_t'(req_q.req_type);
		tgt_ok = int'(req_q.target_thread) < THREAD_SLOTS;
		m_ok = int'(req_q.mutex_sel) < MUTEX_COUNT;
		c_ok = int'(req_q.cond_sel) < COND_COUNT;
		tidx = TW'(req_q.target_thread);
		midx = MW'(req_q.mutex_sel);
		cidx = CW'(req_q.cond_sel);
		mq = QW'(midx) + QW'(1);
		cq = QW'(cidx) + QW'(1 + MUTEX_COUNT);
		bad = 1'b0;
		p_push = 1'b0;
		p_pq = '0;
		p_pt = cur_q;
		p_move = 1'b0;
		p_src = mq;
		p_rel = 1'b0;
		p_disp = 1'b0;
		do_create = 1'b0;
		do_exit = 1'b0;
		do_join = 1'b0;
		do_lock = 1'b0;
		unique case (kind)
			tss_pkg::REQ_CREATE: begin
				if (!tgt_ok || live_q[tidx]) begin
					bad = 1'b1;
				end else begin
					do_create = 1'b1;
					p_push = 1'b1;
					p_pt = tidx;
				end
			end
			tss_pkg::REQ_YIELD: begin
				p_push = cv_q;
				p_disp = 1'b1;
			end
			tss_pkg::REQ_EXIT: begin
				if (!cv_q) begin
					bad = 1'b1;
				end else begin
					do_exit = 1'b1;
					p_push = jv_q[cur_q];
					p_pt = jthr_q[cur_q];
					p_disp = 1'b1;
				end
			end
			tss_pkg::REQ_JOIN: begin
				if (!cv_q || !tgt_ok || tidx == cur_q) begin
					bad = 1'b1;
				end else if (fin_q[tidx]) begin
					bad = 1'b0;
				end else if (!live_q[tidx] || jv_q[tidx]) begin
					bad = 1'b1;
				end else begin
					do_join = 1'b1;
					p_disp = 1'b1;
				end
			end
			tss_pkg::REQ_LOCK: begin
				if (!cv_q || !m_ok) begin
					bad = 1'b1;
				end else if (!lock_q[midx]) begin
					do_lock = 1'b1;
				end else begin
					p_push = 1'b1;
					p_pq = mq;
					p_disp = 1'b1;
				end
			end
			tss_pkg::REQ_UNLOCK: begin
				if (!m_ok) begin
					bad = 1'b1;
				end else begin
					p_move = 1'b1;
					p_rel = 1'b1;
				end
			end
			tss_pkg::REQ_WAIT: begin
				if (!cv_q || !c_ok || (req_q.with_mutex && !m_ok)) begin
					bad = 1'b1;
				end else begin
					p_push = 1'b1;
					p_pq = cq;
					p_move = req_q.with_mutex;
					p_rel = 1'b1;
					p_disp = 1'b1;
				end
			end
			tss_pkg::REQ_SIGNAL: begin
				if (!c_ok) begin
					bad = 1'b1;
				end else begin
					p_move = 1'b1;
					p_src = cq;
				end
			end
		endcase
	end

	assign rsp_load = (st_q == C_RESULT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		st_nxt = st_q;
		eng_ctl = '{start: 1'b0, op: tss_pkg::QOP_PUSH};
		eng_queue = '0;
		eng_thread = push_t_q;
		try_push = 1'b0;
		try_move = 1'b0;
		try_disp = 1'b0;
		clr_lock = 1'b0;
		disp_none = 1'b0;
		unique case (st_q)
			C_IDLE: begin
				if (req_valid)
					st_nxt = C_DECODE;
			end
			C_DECODE: begin
				st_nxt = bad ? C_RESULT : C_LAUNCH;
			end
			C_LAUNCH: begin
				try_push = 1'b1;
			end
			C_PUSH_W: begin
				try_move = eng_done;
			end
			C_MOVE_POP_W: begin
				if (eng_done) begin
					eng_ctl = '{start: 1'b1, op: tss_pkg::QOP_PUSH};
					eng_queue = '0;
					eng_thread = eng_pop;
					st_nxt = C_MOVE_PUSH_W;
				end
			end
			C_MOVE_PUSH_W: begin
				try_disp = eng_done;
			end
			C_DISP_W: begin
				if (eng_done)
					st_nxt = C_RESULT;
			end
			C_RESULT: begin
				if (rsp_load)
					st_nxt = C_IDLE;
			end
		endcase

		if (try_push) begin
			if (push_en_q) begin
				eng_ctl = '{start: 1'b1, op: tss_pkg::QOP_PUSH};
				eng_queue = push_q_q;
				eng_thread = push_t_q;
				st_nxt = C_PUSH_W;
			end else begin
				try_move = 1'b1;
			end
		end
		if (try_move) begin
			if (move_en_q && !eng_empty[move_src_q]) begin
				eng_ctl = '{start: 1'b1, op: tss_pkg::QOP_POP};
				eng_queue = move_src_q;
				st_nxt = C_MOVE_POP_W;
			end else begin
				clr_lock = move_en_q && move_rel_q;
				try_disp = 1'b1;
			end
		end
		if (try_disp) begin
			if (!disp_en_q) begin
				st_nxt = C_RESULT;
			end else if (eng_empty[0]) begin
				disp_none = 1'b1;
				st_nxt = C_RESULT;
			end else begin
				eng_ctl = '{start: 1'b1, op: tss_pkg::QOP_POP};
				eng_queue = '0;
				st_nxt = C_DISP_W;
			end
		end
	end

	assign sw = (cv_q != was_cv_q) || (cv_q && (cur_q != was_cur_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			req_q <= '0;
			cur_q <= '0;
			cv_q <= 1'b1;
			live_q <= THREAD_SLOTS'(1);
			fin_q <= '0;
			jv_q <= '0;
			jthr_q <= '{default: '0};
			lock_q <= '0;
			status_q <= tss_pkg::ST_OK;
			was_cv_q <= 1'b1;
			was_cur_q <= '0;
			push_en_q <= 1'b0;
			push_q_q <= '0;
			push_t_q <= '0;
			move_en_q <= 1'b0;
			move_src_q <= '0;
			move_rel_q <= 1'b0;
			move_m_q <= '0;
			disp_en_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == C_IDLE && req_valid)
				req_q <= req;
			if (st_q == C_DECODE) begin
				push_en_q <= p_push;
				push_q_q <= p_pq;
				push_t_q <= p_pt;
				move_en_q <= p_move;
				move_src_q <= p_src;
				move_rel_q <= p_rel;
				move_m_q <= midx;
				disp_en_q <= p_disp;
				was_cv_q <= cv_q;
				was_cur_q <= cur_q;
				status_q <= bad ? tss_pkg::ST_INVALID : tss_pkg::ST_OK;
				if (do_create) begin
					live_q[tidx] <= 1'b1;
					fin_q[tidx] <= 1'b0;
					jv_q[tidx] <= 1'b0;
				end
				if (do_exit) begin
					fin_q[cur_q] <= 1'b1;
					live_q[cur_q] <= 1'b0;
					jv_q[cur_q] <= 1'b0;
				end
				if (do_join) begin
					jv_q[tidx] <= 1'b1;
					jthr_q[tidx] <= cur_q;
				end
				if (do_lock)
					lock_q[midx] <= 1'b1;
			end
			if (clr_lock)
				lock_q[move_m_q] <= 1'b0;
			if (disp_none) begin
				cv_q <= 1'b0;
				status_q <= tss_pkg::ST_EMPTY;
			end
			if (st_q == C_DISP_W && eng_done) begin
				cur_q <= eng_pop;
				cv_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q.running_now <= cv_q ? RUN_W'(cur_q) : '0;
				rsp_q.running_ok <= cv_q;
				rsp_q.switched <= sw;
				rsp_q.status <= status_q;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (st_q != C_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef ASSERT_OFF
	a_disp_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == C_DISP_W && eng_done) |=> cv_q)
		else $error("dispatch left no running thread");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.running_ok || rsp.running_now == '0))
		else $error("running_now set with no running thread");

	a_bad_still: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == tss_pkg::ST_INVALID) |-> !rsp.switched)
		else $error("invalid request switched thread");

	a_queue_range: assert property (@(posedge clk) disable iff (!arst_n)
		eng_ctl.start |-> int'(eng_queue) < QUEUE_COUNT)
		else $error("queue index out of range");
`endif

endmodule

FILE: hdl/tss_queue_engine.sv
// Linked queue engine: head/tail memory, next-link memory and empty flags.
module tss_queue_engine #(
	parameter int THREAD_SLOTS = tss_pkg::THREAD_SLOTS_DEF,
	parameter int QUEUE_COUNT = tss_pkg::QUEUE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tss_pkg::qe_ctl_t               ctl,
	input  logic [$clog2(QUEUE_COUNT)-1:0]  queue,
	input  logic [$clog2(THREAD_SLOTS)-1:0] thread,
	output logic                           done,
	output logic [$clog2(THREAD_SLOTS)-1:0] pop_thread,
	output logic [QUEUE_COUNT-1:0]         empty
);

	localparam int TW = $clog2(THREAD_SLOTS);
	localparam int QW = $clog2(QUEUE_COUNT);

	typedef enum logic [1:0] {
		E_IDLE,
		E_HT,
		E_LINK
	} eng_state_t;

	eng_state_t st_q;
	tss_pkg::qe_op_t op_q;
	logic [QW-1:0] q_q;
	logic [TW-1:0] t_q;
	logic [TW-1:0] pop_q;
	logic done_q;
	logic [QUEUE_COUNT-1:0] empty_q;

	logic [TW-1:0] link_mem [THREAD_SLOTS];
	logic [2*TW-1:0] ht_mem [QUEUE_COUNT];
	logic [TW-1:0] link_rd_q;
	logic [2*TW-1:0] ht_rd_q;

	logic [TW-1:0] head;
	logic [TW-1:0] tail;
	logic link_we;
	logic ht_we;
	logic [2*TW-1:0] ht_wd;

	assign head = ht_rd_q[2*TW-1:TW];
	assign tail = ht_rd_q[TW-1:0];

	always_comb begin
		link_we = 1'b0;
		ht_we = 1'b0;
		ht_wd = ht_rd_q;
		unique case (st_q)
			E_HT: begin
				if (op_q == tss_pkg::QOP_PUSH) begin
					link_we = !empty_q[q_q];
					ht_we = 1'b1;
					ht_wd = {(empty_q[q_q] ? t_q : head), t_q};
				end
			end
			E_LINK: begin
				ht_we = 1'b1;
				ht_wd = {link_rd_q, tail};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ht_we)
			ht_mem[q_q] <= ht_wd;
		if (link_we)
			link_mem[tail] <= t_q;
		if (ctl.start)
			ht_rd_q <= ht_mem[queue];
		if (st_q == E_HT)
			link_rd_q <= link_mem[head];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			op_q <= tss_pkg::QOP_PUSH;
			q_q <= '0;
			t_q <= '0;
			pop_q <= '0;
			done_q <= 1'b0;
			empty_q <= '1;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (ctl.start) begin
						st_q <= E_HT;
						op_q <= ctl.op;
						q_q <= queue;
						t_q <= thread;
					end
				end
				E_HT: begin
					pop_q <= head;
					if (op_q == tss_pkg::QOP_PUSH) begin
						empty_q[q_q] <= 1'b0;
						done_q <= 1'b1;
						st_q <= E_IDLE;
					end else if (head == tail) begin
						empty_q[q_q] <= 1'b1;
						done_q <= 1'b1;
						st_q <= E_IDLE;
					end else begin
						st_q <= E_LINK;
					end
				end
				E_LINK: begin
					done_q <= 1'b1;
					st_q <= E_IDLE;
				end
				default: begin
					st_q <= E_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign pop_thread = pop_q;
	assign empty = empty_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> st_q == E_IDLE)
		else $error("queue op started while engine busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (st_q == E_IDLE && !$past(done_q)))
		else $error("done pulse out of place");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == E_HT && op_q == tss_pkg::QOP_PUSH) |=> !empty_q[q_q])
		else $error("queue still empty after push");
`endif

endmodule

FILE: tb/thread_sched_monitor.sv
// Channel monitor for the thread sync scheduler: predicts each event's result and compares.
module thread_sched_monitor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  tss_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  tss_pkg::rsp_t rsp,
	output int            fail_count,
	output int            outstanding,
	output int            results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = tss_pkg::THREAD_SLOTS_DEF;
	localparam int LOCKS = tss_pkg::MUTEX_COUNT_DEF;
	localparam int QUEUES = tss_pkg::QUEUE_COUNT_DEF;
	localparam int READY_Q = 0;
	localparam int COND_BASE = 1 + tss_pkg::MUTEX_COUNT_DEF;
	localparam int TW = tss_pkg::THREAD_W;
	localparam int JW = tss_pkg::THREAD_W + 1;
	localparam logic [JW-1:0] NO_JOINER = JW'(SLOTS);

	logic [TW-1:0] next_link [SLOTS];
	logic [TW-1:0] q_first [QUEUES];
	logic [TW-1:0] q_last [QUEUES];
	logic          q_void [QUEUES];
	logic          lock_held [LOCKS];
	logic          done_mark [SLOTS];
	logic          live [SLOTS];
	logic [JW-1:0] joiner [SLOTS];
	logic [TW-1:0] cur;
	logic          cur_ok;

	tss_pkg::rsp_t awaited_outcomes [$];
	tss_pkg::rsp_t want;
	tss_pkg::rsp_t outcome;
	int   mismatches;
	int   matched;

	task report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task reset_sched();
		for (int i = 0; i < SLOTS; i++) begin
			next_link[i] = '0;
			done_mark[i] = 1'b0;
			live[i] = (i == 0);
			joiner[i] = NO_JOINER;
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_first[i] = '0;
			q_last[i] = '0;
			q_void[i] = 1'b1;
		end
		for (int i = 0; i < LOCKS; i++)
			lock_held[i] = 1'b0;
		cur = '0;
		cur_ok = 1'b1;
	endtask

	task q_append(input int q, input logic [TW-1:0] t);
		if (q_void[q]) begin
			q_first[q] = t;
			q_void[q] = 1'b0;
		end else begin
			next_link[q_last[q]] = t;
		end
		q_last[q] = t;
	endtask

	task q_take(input int q, output logic [TW-1:0] t);
		t = q_first[q];
		if (t == q_last[q])
			q_void[q] = 1'b1;
		else
			q_first[q] = next_link[t];
	endtask

	task run_next(output tss_pkg::status_t st);
		if (q_void[READY_Q]) begin
			cur_ok = 1'b0;
			st = tss_pkg::ST_EMPTY;
		end else begin
			q_take(READY_Q, cur);
			cur_ok = 1'b1;
			st = tss_pkg::ST_OK;
		end
	endtask

	// hand the mutex to its first waiter, else free it
	task free_lock(input int m);
		logic [TW-1:0] w;
		if (!q_void[1 + m]) begin
			q_take(1 + m, w);
			q_append(READY_Q, w);
		end else begin
			lock_held[m] = 1'b0;
		end
	endtask

	task predict_event(input tss_pkg::req_t r, output tss_pkg::rsp_t o);
		logic              was_ok;
		logic [TW-1:0]     was_cur;
		logic [TW-1:0]     t;
		logic [TW-1:0]     w;
		int                m;
		int                cq;
		logic              bad;
		tss_pkg::status_t  st;
		was_ok = cur_ok;
		was_cur = cur;
		t = r.target_thread;
		m = int'(r.mutex_sel);
		cq = COND_BASE + int'(r.cond_sel);
		bad = 1'b0;
		st = tss_pkg::ST_OK;
		unique case (tss_pkg::req_kind_t'(r.req_type))
			tss_pkg::REQ_CREATE: begin
				if (live[t]) begin
					bad = 1'b1;
				end else begin
					live[t] = 1'b1;
					done_mark[t] = 1'b0;
					joiner[t] = NO_JOINER;
					q_append(READY_Q, t);
				end
			end
			tss_pkg::REQ_YIELD: begin
				if (cur_ok)
					q_append(READY_Q, cur);
				run_next(st);
			end
			tss_pkg::REQ_EXIT: begin
				if (!cur_ok) begin
					bad = 1'b1;
				end else begin
					done_mark[cur] = 1'b1;
					live[cur] = 1'b0;
					if (joiner[cur] != NO_JOINER)
						q_append(READY_Q, joiner[cur][TW-1:0]);
					joiner[cur] = NO_JOINER;
					run_next(st);
				end
			end
			tss_pkg::REQ_JOIN: begin
				if (!cur_ok || t == cur) begin
					bad = 1'b1;
				end else if (!done_mark[t]) begin
					if (!live[t] || joiner[t] != NO_JOINER) begin
						bad = 1'b1;
					end else begin
						joiner[t] = {1'b0, cur};
						run_next(st);
					end
				end
			end
			tss_pkg::REQ_LOCK: begin
				if (!cur_ok) begin
					bad = 1'b1;
				end else if (!lock_held[m]) begin
					lock_held[m] = 1'b1;
				end else begin
					q_append(1 + m, cur);
					run_next(st);
				end
			end
			tss_pkg::REQ_UNLOCK: begin
				free_lock(m);
			end
			tss_pkg::REQ_WAIT: begin
				if (!cur_ok) begin
					bad = 1'b1;
				end else begin
					q_append(cq, cur);
					if (r.with_mutex)
						free_lock(m);
					run_next(st);
				end
			end
			default: begin
				if (!q_void[cq]) begin
					q_take(cq, w);
					q_append(READY_Q, w);
				end
			end
		endcase
		o.running_now = cur_ok ? cur : '0;
		o.running_ok = cur_ok;
		o.switched = (cur_ok != was_ok) || (cur_ok && cur != was_cur);
		o.status = bad ? tss_pkg::ST_INVALID : st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_sched();
			awaited_outcomes.delete();
			mismatches = 0;
			matched = 0;
			fail_count <= 0;
			outstanding <= 0;
			results_seen <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_outcomes.size() == 0) begin
					report_mismatch($sformatf("result %h with no event waiting", rsp));
				end else begin
					want = awaited_outcomes.pop_front();
					if (rsp.running_now !== want.running_now)
						report_mismatch($sformatf("running_now got %0d, expected %0d",
							rsp.running_now, want.running_now));
					if (rsp.running_ok !== want.running_ok)
						report_mismatch($sformatf("running_ok got %0d, expected %0d",
							rsp.running_ok, want.running_ok));
					if (rsp.switched !== want.switched)
						report_mismatch($sformatf("switched got %0d, expected %0d",
							rsp.switched, want.switched));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d, expected %0d",
							rsp.status, want.status));
					matched++;
				end
			end
			if (req_valid && !req_stall) begin
				predict_event(req, outcome);
				awaited_outcomes.push_back(outcome);
			end
			fail_count <= mismatches;
			outstanding <= awaited_outcomes.size();
			results_seen <= matched;
		end
	end

endmodule

FILE: tb/thread_sync_scheduler_unit_tb.sv
// Testbench top for the thread sync scheduler: clock, reset, event stimulus and verdict.
module thread_sync_scheduler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_EVENTS = 1750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	tss_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	tss_pkg::rsp_t rsp;

	int fail_count;
	int outstanding;
	int results_seen;
	bit quiet = 1'b0;
	bit held_off = 1'b0;

	always #5 clk = ~clk;

	thread_sync_scheduler_unit dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	thread_sched_monitor monitor (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.fail_count,
		.outstanding,
		.results_seen
	);

	function automatic tss_pkg::req_t make_req(input tss_pkg::req_kind_t kind, input int t,
		input int m, input int c, input bit wm);
		tss_pkg::req_t r;
		r.req_type = kind;
		r.target_thread = tss_pkg::THREAD_W'(t);
		r.mutex_sel = tss_pkg::MUTEX_W'(m);
		r.cond_sel = tss_pkg::COND_W'(c);
		r.with_mutex = wm;
		return r;
	endfunction

	function automatic tss_pkg::req_t rand_event();
		int                 pick;
		tss_pkg::req_kind_t kind;
		pick = $urandom_range(99);
		if (pick < 14)
			kind = tss_pkg::REQ_CREATE;
		else if (pick < 30)
			kind = tss_pkg::REQ_YIELD;
		else if (pick < 38)
			kind = tss_pkg::REQ_EXIT;
		else if (pick < 48)
			kind = tss_pkg::REQ_JOIN;
		else if (pick < 66)
			kind = tss_pkg::REQ_LOCK;
		else if (pick < 80)
			kind = tss_pkg::REQ_UNLOCK;
		else if (pick < 89)
			kind = tss_pkg::REQ_WAIT;
		else
			kind = tss_pkg::REQ_SIGNAL;
		// keep most traffic on a few mutexes and condition variables to force contention
		return make_req(kind, $urandom_range(15),
			($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1),
			($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1),
			$urandom_range(1));
	endfunction

	task automatic offer(input tss_pkg::req_t r);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(99) < 10)
			gap = $urandom_range(6, 1);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	// hold the sender until every expected result is back
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : result_side
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= 400) begin
				held_off = 1'b1;
				hold = 300;
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= !quiet && ($urandom_range(99) < 10);
			end
		end
	end

	initial begin : stimulus
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		offer(make_req(tss_pkg::REQ_YIELD, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_CREATE, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_CREATE, 15, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_CREATE, 1, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_JOIN, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_JOIN, 7, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_LOCK, 0, 7, 0, 0));
		offer(make_req(tss_pkg::REQ_LOCK, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_YIELD, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_LOCK, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_JOIN, 15, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_JOIN, 15, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_UNLOCK, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_UNLOCK, 0, 7, 0, 0));
		offer(make_req(tss_pkg::REQ_UNLOCK, 0, 7, 0, 0));
		offer(make_req(tss_pkg::REQ_WAIT, 0, 0, 7, 1));
		offer(make_req(tss_pkg::REQ_SIGNAL, 0, 0, 3, 0));
		offer(make_req(tss_pkg::REQ_SIGNAL, 0, 0, 7, 0));
		offer(make_req(tss_pkg::REQ_EXIT, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_JOIN, 15, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_CREATE, 15, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_WAIT, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_EXIT, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_EXIT, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_EXIT, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_LOCK, 0, 3, 0, 0));
		offer(make_req(tss_pkg::REQ_WAIT, 0, 7, 7, 1));
		offer(make_req(tss_pkg::REQ_YIELD, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_SIGNAL, 0, 0, 0, 0));
		offer(make_req(tss_pkg::REQ_YIELD, 0, 0, 0, 0));
		drain();

		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			if (i == 700)
				quiet = 1'b1;
			if (i == 1000)
				quiet = 1'b0;
			if (i == 1200)
				drain();
			offer(rand_event());
		end
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
